// ===== design/vdlp_pkg.sv =====
// Shared types and constants for the vector display-list processor.
package vdlp_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE_RAM   = 2'd0,
        FUNC_WRITE_COLOR = 2'd1,
        FUNC_START       = 2'd2,
        FUNC_STEP        = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_LONG   = 3'd0,
        OP_HALT   = 3'd1,
        OP_SHORT  = 3'd2,
        OP_STATUS = 3'd3,
        OP_CENTRE = 3'd4,
        OP_CALL   = 3'd5,
        OP_RETURN = 3'd6,
        OP_JUMP   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_UNDERFLOW = 2'd1,
        FAULT_OVERFLOW  = 2'd2
    } fault_t;

    localparam int EN_RED   = 2;
    localparam int EN_GREEN = 1;
    localparam int EN_BLUE  = 0;

    localparam logic [9:0] CENTRE_POS = 10'd512;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] address;
        logic [15:0] data;
    } in_item_t;

    typedef struct packed {
        logic               drawn;
        logic               is_point;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               halted;
        logic [1:0]         fault;
    } out_item_t;

    // multiplier request from the sequencer
    typedef struct packed {
        logic               start;
        logic signed [15:0] operand;
    } mul_req_t;

endpackage

// ===== design/vector_display_list_processor_unit.sv =====
// Top level of the vector display-list processor: sequencer, memories, result register.
//
//  channel | signals                    | payload
//  in      | in_valid / in_ready        | in_item  (func, address, data)
//  out     | out_valid / out_ready      | out_item (segment, intensity, status)
//
// Writes and start are taken in the idle state. A step reads one instruction
// word per registered RAM read (READ1, then READ2 for a long vector); a vector
// then sends its X and Y deltas through the one shared multiplier (MULX, MULY)
// before OUT loads the result register.
// After reset the vector RAM is cleared by a sweep over all RAM_WORDS words;
// no request is taken meanwhile. A result waits in the output register;
// the next request is taken only once the result is delivered.
module vector_display_list_processor_unit
    import vdlp_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int STACK_DEPTH   = 8,
    parameter int RAM_WORDS     = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int AW = $clog2(RAM_WORDS);
    localparam int SW = $clog2(STACK_DEPTH);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ1 = 7'b0000100,
        ST_READ2 = 7'b0001000,
        ST_MULX  = 7'b0010000,
        ST_MULY  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;

    logic [15:0] ram [RAM_WORDS];
    logic [15:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic        ram_we;
    logic [AW-1:0] waddr;
    logic [15:0] wdata;

    logic [2:0]  color_en_reg [16];
    logic [15:0] color_valid_reg;
    logic [11:0] stack_reg [STACK_DEPTH];

    logic [AW-1:0] pc_reg, pc_next;
    logic [SW-1:0] sp_reg, sp_next;
    logic [15:0] scale_reg, scale_next;
    logic [3:0]  inten_reg, inten_next;
    logic [3:0]  csel_reg, csel_next;
    logic [31:0] bx_reg, bx_next, by_reg, by_next;
    logic        fin_reg, fin_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic [31:0] dx_reg, dx_next;
    logic        outv_reg, outv_next;
    out_item_t   out_reg, out_next;

    mul_req_t    mreq;
    logic [31:0] product;
    logic        stack_we;
    logic [SW-1:0] stack_wa;

    vdlp_mul u_mul (
        .clk     (clk),
        .req     (mreq),
        .scale   (scale_reg),
        .product (product)
    );

    function automatic logic [15:0] screen(input logic [31:0] v);
        logic [31:0] s;
        s = 32'($signed(v) >>> FRACTION_BITS);
        return s[15:0];
    endfunction

    // vector word fields
    op_t         op;
    logic [15:0] xv, yv;
    logic [3:0]  zc, zsel;
    logic [7:0]  zint;
    logic [2:0]  en;
    logic [31:0] ex, ey;
    logic [12:0] tgt;
    logic [2:0]  sb;
    logic [7:0]  lv;
    logic [31:0] lsh;

    always_comb
    begin
        op = op_t'(first_reg[15:13]);
        if (op == OP_LONG)
        begin
            xv = 16'($signed(second_reg[11:0]));
            yv = 16'($signed(first_reg[11:0]));
            zc = second_reg[15:12] & 4'he;
        end
        else
        begin
            xv = {{10{first_reg[4]}}, first_reg[4:0], 1'b0};
            yv = {{10{first_reg[12]}}, first_reg[12:8], 1'b0};
            zc = first_reg[7:4] & 4'he;
        end
        zsel = (zc == 4'd2) ? inten_reg : zc;
        // code bits in the upper three bits, low five bits forced on
        zint = (zsel != 4'd0) ? {zsel[3:1], 5'h1f} : 8'd0;
        en   = color_valid_reg[csel_reg] ? color_en_reg[csel_reg] : 3'd0;
        ex   = bx_reg + dx_reg;
        ey   = by_reg - product;
        tgt  = first_reg[12:0];
        sb   = first_reg[10:8];
        lv   = ~first_reg[7:0];
        lsh  = ({24'd0, lv} << FRACTION_BITS) >> (32'(sb) + 32'd8);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        scale_next  = scale_reg;
        inten_next  = inten_reg;
        csel_next   = csel_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        fin_next    = fin_reg;
        first_next  = first_reg;
        second_next = second_reg;
        dx_next     = dx_reg;
        outv_next   = outv_reg;
        out_next    = out_reg;
        raddr       = pc_reg;
        ram_we      = 1'b0;
        waddr       = in_item.address[AW-1:0];
        wdata       = in_item.data;
        stack_we    = 1'b0;
        stack_wa    = sp_reg;
        mreq.start   = 1'b0;
        mreq.operand = xv;
        in_ready    = (state_reg == ST_IDLE) && !outv_reg;

        if (outv_reg && out_ready)
        begin
            outv_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                waddr  = clr_reg[AW-1:0];
                wdata  = 16'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(RAM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (func_t'(in_item.func))
                        FUNC_WRITE_RAM: ram_we = 1'b1;
                        FUNC_START:
                        begin
                            pc_next    = '0;
                            sp_next    = '0;
                            scale_next = '0;
                            inten_next = '0;
                            csel_next  = '0;
                            bx_next    = '0;
                            by_next    = '0;
                            fin_next   = 1'b0;
                        end
                        FUNC_STEP:
                        begin
                            if (fin_reg)
                            begin
                                out_next       = '0;
                                out_next.halted = 1'b1;
                                outv_next      = 1'b1;
                            end
                            else
                            begin
                                pc_next    = pc_reg + 1'b1;
                                state_next = ST_READ1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ1:
            begin
                first_next = rdata_reg;
                if (rdata_reg[15:13] == OP_LONG)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_READ2;
                end
                else if (rdata_reg[15:13] == OP_SHORT)
                begin
                    state_next = ST_MULX;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_READ2:
            begin
                second_next = rdata_reg;
                state_next  = ST_MULX;
            end
            ST_MULX:
            begin
                mreq.start   = 1'b1;
                mreq.operand = xv;
                state_next   = ST_MULY;
            end
            ST_MULY:
            begin
                dx_next      = product;
                mreq.start   = 1'b1;
                mreq.operand = yv;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                out_next   = '0;
                outv_next  = 1'b1;
                state_next = ST_IDLE;
                case (op)
                    OP_LONG, OP_SHORT:
                    begin
                        if (zint != 8'd0)
                        begin
                            out_next.drawn    = 1'b1;
                            out_next.is_point = (dx_reg == '0) && (product == '0);
                            out_next.start_x  = screen(bx_reg);
                            out_next.start_y  = screen(by_reg);
                            out_next.end_x    = screen(ex);
                            out_next.end_y    = screen(ey);
                            out_next.red      = en[EN_RED] ? zint : 8'd0;
                            out_next.green    = en[EN_GREEN] ? zint : 8'd0;
                            out_next.blue     = en[EN_BLUE] ? zint : 8'd0;
                        end
                        bx_next = ex;
                        by_next = ey;
                    end
                    OP_STATUS:
                    begin
                        if (first_reg[12])
                        begin
                            scale_next = lsh[15:0];
                        end
                        else
                        begin
                            inten_next = first_reg[7:4];
                            csel_next  = first_reg[3:0];
                        end
                    end
                    OP_CENTRE:
                    begin
                        bx_next = 32'(CENTRE_POS) << FRACTION_BITS;
                        by_next = 32'(CENTRE_POS) << FRACTION_BITS;
                    end
                    OP_RETURN:
                    begin
                        if (sp_reg == '0)
                        begin
                            out_next.fault = FAULT_UNDERFLOW;
                            fin_next = 1'b1;
                            sp_next  = SW'(STACK_DEPTH - 1);
                        end
                        else
                        begin
                            sp_next = sp_reg - 1'b1;
                            pc_next = stack_reg[sp_reg - 1'b1][AW-1:0];
                        end
                    end
                    OP_HALT: fin_next = 1'b1;
                    default:
                    begin
                        if (tgt == '0)
                        begin
                            fin_next = 1'b1;
                        end
                        else if (op == OP_JUMP)
                        begin
                            pc_next = tgt[AW-1:0];
                        end
                        else
                        begin
                            stack_we = 1'b1;
                            if (sp_reg == SW'(STACK_DEPTH - 1))
                            begin
                                out_next.fault = FAULT_OVERFLOW;
                                fin_next = 1'b1;
                                sp_next  = '0;
                            end
                            else
                            begin
                                sp_next = sp_reg + 1'b1;
                                pc_next = tgt[AW-1:0];
                            end
                        end
                    end
                endcase
                out_next.halted = fin_next;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // vector RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[waddr] <= wdata;
        end
        rdata_reg <= ram[raddr];
    end

    // return stack and color table
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_reg[stack_wa] <= 12'(pc_reg);
        end
        if (state_reg == ST_IDLE && in_valid && in_ready
            && in_item.func == FUNC_WRITE_COLOR)
        begin
            color_en_reg[in_item.address[3:0]] <=
                {~in_item.data[3], ~(in_item.data[1] & in_item.data[0]), ~in_item.data[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_valid_reg <= '0;
        end
        else if (state_reg == ST_IDLE && in_valid && in_ready
                 && in_item.func == FUNC_WRITE_COLOR)
        begin
            color_valid_reg[in_item.address[3:0]] <= 1'b1;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            sp_reg    <= '0;
            scale_reg <= '0;
            inten_reg <= '0;
            csel_reg  <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            fin_reg   <= 1'b1;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            scale_reg <= scale_next;
            inten_reg <= inten_next;
            csel_reg  <= csel_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            fin_reg   <= fin_next;
            outv_reg  <= outv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        dx_reg     <= dx_next;
        out_reg    <= out_next;
    end

    assign out_valid = outv_reg;
    assign out_item  = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.fault != FAULT_NONE) |-> out_item.halted)
        else $error("fault without halt");
    a_point_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.is_point) |-> out_item.drawn)
        else $error("point flag on undrawn segment");
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_valid)
        else $error("result lost");

endmodule

// ===== design/vdlp_mul.sv =====
// Shared delta multiplier: signed operand times unsigned scale, registered.
module vdlp_mul
    import vdlp_pkg::*;
(
    input  logic        clk,
    input  mul_req_t    req,
    input  logic [15:0] scale,
    output logic [31:0] product
);

    logic [31:0] product_reg;
    logic [31:0] product_next;

    // multiply a sign-extended delta by the zero-extended scale
    always_comb
    begin
        product_next = product_reg;
        if (req.start)
        begin
            product_next = 32'($signed({{16{req.operand[15]}}, req.operand})
                             * $signed({16'd0, scale}));
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

// ===== test/vector_display_list_processor_unit_test.sv =====
// Testbench for the vector display-list processor: directed table, then random programs.
module vector_display_list_processor_unit_test;
    import vdlp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = 16;
    localparam int DEPTH      = 8;
    localparam int WORDS      = 4096;
    localparam int RANDOM_REQ = 1700;
    localparam int STALL_MAX  = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    vector_display_list_processor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // shadow copy of the display engine
    logic [15:0] shadow_ram [WORDS];
    logic [2:0]  shadow_color [16];
    logic [11:0] shadow_stack [DEPTH];
    logic [11:0] shadow_pc;
    logic [2:0]  shadow_sp;
    logic [15:0] shadow_scale;
    logic [3:0]  shadow_level;
    logic [3:0]  shadow_csel;
    logic [31:0] shadow_bx;
    logic [31:0] shadow_by;
    logic        shadow_done;

    out_item_t segment_queue [$];
    int        error_count;
    int        idle_cycles;
    int        issued;
    bit        stimulus_done;
    bit        hold_off;
    bit        stack_written [DEPTH];

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } table_row_t;
    table_row_t directed_table [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] to_screen(input logic [31:0] v);
        logic signed [31:0] s;
        s = v;
        return 16'(s >>> FRAC);
    endfunction

    // apply one request to the shadow model; returns 1 when a segment is due
    function automatic bit predict_segment(input in_item_t req, output out_item_t res);
        logic [15:0] first;
        logic [15:0] second;
        logic [2:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [7:0]  z;
        logic [2:0]  en;
        logic [12:0] tgt;
        logic [3:0]  sh;
        logic [31:0] lv;
        res = '0;
        case (func_t'(req.func))
            FUNC_WRITE_RAM:
            begin
                shadow_ram[req.address] = req.data;
                return 1'b0;
            end
            FUNC_WRITE_COLOR:
            begin
                shadow_color[req.address[3:0]] =
                    {~req.data[3], ~(req.data[1] & req.data[0]), ~req.data[2]};
                return 1'b0;
            end
            FUNC_START:
            begin
                shadow_pc = '0;
                shadow_sp = '0;
                shadow_scale = '0;
                shadow_level = '0;
                shadow_csel = '0;
                shadow_bx = '0;
                shadow_by = '0;
                shadow_done = 1'b0;
                return 1'b0;
            end
            default: ;
        endcase
        if (!shadow_done)
        begin
            first = shadow_ram[shadow_pc];
            shadow_pc = shadow_pc + 12'd1;
            op = first[15:13];
            if (op == OP_LONG || op == OP_SHORT)
            begin
                if (op == OP_LONG)
                begin
                    second = shadow_ram[shadow_pc];
                    shadow_pc = shadow_pc + 12'd1;
                    x = {{20{second[11]}}, second[11:0]};
                    y = {{20{first[11]}}, first[11:0]};
                    z = {4'd0, second[15:13], 1'b0};
                end
                else
                begin
                    x = {{26{first[4]}}, first[4:0], 1'b0};
                    y = {{26{first[12]}}, first[12:8], 1'b0};
                    z = {4'd0, first[7:5], 1'b0};
                end
                if (z == 8'd2)
                    z = {4'd0, shadow_level};
                if (z != 8'd0)
                    z = {z[3:0], 4'hf} | 8'h1f;
                dx = x * {16'd0, shadow_scale};
                dy = y * {16'd0, shadow_scale};
                if (z != 8'd0)
                begin
                    en = shadow_color[shadow_csel];
                    res.drawn = 1'b1;
                    res.is_point = (dx == 0 && dy == 0);
                    res.start_x = to_screen(shadow_bx);
                    res.start_y = to_screen(shadow_by);
                    res.end_x = to_screen(shadow_bx + dx);
                    res.end_y = to_screen(shadow_by - dy);
                    res.red = en[EN_RED] ? z : 8'd0;
                    res.green = en[EN_GREEN] ? z : 8'd0;
                    res.blue = en[EN_BLUE] ? z : 8'd0;
                end
                shadow_bx = shadow_bx + dx;
                shadow_by = shadow_by - dy;
            end
            else if (op == OP_STATUS)
            begin
                if (first[12])
                begin
                    sh = {1'b0, first[10:8]} + 4'd8;
                    lv = {24'd0, ~first[7:0]} << FRAC;
                    shadow_scale = 16'(lv >> sh);
                end
                else
                begin
                    shadow_level = first[7:4];
                    shadow_csel = first[3:0];
                end
            end
            else if (op == OP_CENTRE)
            begin
                shadow_bx = 32'(CENTRE_POS) << FRAC;
                shadow_by = 32'(CENTRE_POS) << FRAC;
            end
            else if (op == OP_RETURN)
            begin
                if (shadow_sp == 0)
                begin
                    res.fault = FAULT_UNDERFLOW;
                    shadow_done = 1'b1;
                    shadow_sp = 3'(DEPTH - 1);
                end
                else
                begin
                    shadow_sp = shadow_sp - 3'd1;
                    shadow_pc = shadow_stack[shadow_sp];
                end
            end
            else if (op == OP_HALT)
                shadow_done = 1'b1;
            else
            begin
                tgt = first[12:0];
                if (tgt == 0)
                    shadow_done = 1'b1;
                else if (op == OP_JUMP)
                    shadow_pc = tgt[11:0];
                else
                begin
                    shadow_stack[shadow_sp] = shadow_pc;
                    if (shadow_sp >= 3'(DEPTH - 1))
                    begin
                        res.fault = FAULT_OVERFLOW;
                        shadow_done = 1'b1;
                        shadow_sp = '0;
                    end
                    else
                    begin
                        shadow_sp = shadow_sp + 3'd1;
                        shadow_pc = tgt[11:0];
                    end
                end
            end
        end
        res.halted = shadow_done;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // next step would return through a stack entry never written since reset
    function automatic bit return_unsafe();
        return !shadow_done && shadow_ram[shadow_pc][15:13] == OP_RETURN &&
               shadow_sp != 0 && !stack_written[shadow_sp - 3'd1];
    endfunction

    // offer one request and wait until it is taken; valid drops only for a gap
    task automatic send_request(input in_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic issue(input in_item_t req);
        out_item_t res;
        if (req.func == FUNC_STEP && !shadow_done &&
            shadow_ram[shadow_pc][15:13] == OP_CALL &&
            shadow_ram[shadow_pc][12:0] != 0)
            stack_written[shadow_sp] = 1'b1;
        if (predict_segment(req, res))
            segment_queue.push_back(res);
        issued++;
        send_request(req);
    endtask

    function automatic in_item_t make_req(input func_t f, input logic [11:0] a,
                                          input logic [15:0] d);
        in_item_t r;
        r.func = f;
        r.address = a;
        r.data = d;
        return r;
    endfunction

    task automatic add_row(input func_t f, input logic [11:0] a, input logic [15:0] d,
                           input bit typed, input out_item_t want);
        table_row_t row;
        row.req = make_req(f, a, d);
        row.typed = typed;
        row.want = want;
        directed_table.push_back(row);
    endtask

    // random word biased toward each opcode with small jump targets
    function automatic logic [15:0] random_instr(input int prog_len);
        logic [15:0] w;
        int r;
        w = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 25)
            w[15:13] = OP_SHORT;
        else if (r < 40)
            w[15:13] = OP_LONG;
        else if (r < 55)
            w[15:13] = OP_STATUS;
        else if (r < 60)
            w[15:13] = OP_CENTRE;
        else if (r < 72)
        begin
            w[15:13] = OP_CALL;
            w[12:0] = 13'($urandom_range(0, prog_len)) | ($urandom_range(0, 7) == 0 ?
                      13'h1000 : 13'h0);
        end
        else if (r < 84)
            w[15:13] = OP_RETURN;
        else if (r < 92)
        begin
            w[15:13] = OP_JUMP;
            w[12:0] = 13'($urandom_range(0, prog_len));
        end
        else
            w[15:13] = OP_HALT;
        return w;
    endfunction

    // program RAM and colors, start, step through; returns never read an unwritten slot
    task automatic run_program();
        int len;
        int steps;
        int k;
        in_item_t r;
        len = $urandom_range(4, 24);
        for (k = 0; k < len; k++)
            issue(make_req(FUNC_WRITE_RAM, 12'(k), random_instr(len)));
        for (k = 0; k < 2; k++)
            issue(make_req(FUNC_WRITE_COLOR, 12'($urandom), 16'($urandom)));
        issue(make_req(FUNC_START, 12'($urandom), 16'($urandom)));
        steps = $urandom_range(5, 30);
        for (k = 0; k < steps; k++)
        begin
            // a return with the stack entry never written is avoided
            if (return_unsafe())
                break;
            r = make_req(FUNC_STEP, 12'($urandom), 16'($urandom));
            issue(r);
        end
    endtask

    // stimulus
    initial
    begin
        out_item_t want;
        out_item_t got;
        table_row_t row;
        in_item_t noise;
        int n;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        error_count = 0;
        issued = 0;
        stimulus_done = 1'b0;
        for (k = 0; k < WORDS; k++)
            shadow_ram[k] = '0;
        for (k = 0; k < 16; k++)
            shadow_color[k] = '0;
        for (k = 0; k < DEPTH; k++)
        begin
            shadow_stack[k] = '0;
            stack_written[k] = 1'b0;
        end
        shadow_pc = '0;
        shadow_sp = '0;
        shadow_scale = '0;
        shadow_level = '0;
        shadow_csel = '0;
        shadow_bx = '0;
        shadow_by = '0;
        shadow_done = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // step while finished after reset
        want = '0;
        want.halted = 1'b1;
        add_row(FUNC_STEP, 12'hfff, 16'hffff, 1, want);
        add_row(FUNC_WRITE_COLOR, 12'hff0, 16'hfff0, 0, '0);
        add_row(FUNC_WRITE_COLOR, 12'h001, 16'h0005, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd0, 16'hc000, 0, '0);
        add_row(FUNC_START, 12'd0, 16'd0, 0, '0);
        want = '0;
        want.halted = 1'b1;
        want.fault = FAULT_UNDERFLOW;
        add_row(FUNC_STEP, 12'd0, 16'd0, 1, want);
        // program: status, max scale, centre, long, short at level code two, blank short
        add_row(FUNC_WRITE_RAM, 12'd0, 16'h60f0, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd1, 16'h7000, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd2, 16'h8000, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd3, 16'h07ff, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd4, 16'he800, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd5, 16'h4f2f, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd6, 16'h5000, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd4095, 16'h3777, 0, '0);
        add_row(FUNC_START, 12'd0, 16'd0, 0, '0);
        for (k = 0; k < 7; k++)
            add_row(FUNC_STEP, 12'd0, 16'd0, 0, '0);
        // overflow: call to self repeatedly
        add_row(FUNC_WRITE_RAM, 12'd0, 16'ha001, 0, '0);
        add_row(FUNC_WRITE_RAM, 12'd1, 16'ha001, 0, '0);
        add_row(FUNC_START, 12'd0, 16'd0, 0, '0);
        n = directed_table.size();
        for (k = 0; k < n; k++)
        begin
            row = directed_table[k];
            if (row.typed)
            begin
                void'(predict_segment(row.req, got));
                segment_queue.push_back(row.want);
            end
            else if (predict_segment(row.req, got))
                segment_queue.push_back(got);
            send_request(row.req);
        end
        for (k = 0; k < 9; k++)
            issue(make_req(FUNC_STEP, 12'($urandom), 16'($urandom)));

        // random programs, with occasional noise
        while (issued < RANDOM_REQ)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise = make_req(func_t'($urandom_range(1, 3)), 12'($urandom),
                                 16'($urandom));
                if (!(noise.func == FUNC_STEP && return_unsafe()))
                    issue(noise);
            end
            else
            begin
                run_program();
            end
        end
        // write the highest address too
        issue(make_req(FUNC_WRITE_RAM, 12'hfff, 16'hffff));
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        out_ready = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (5000) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) < 97) ? 1'b1 : 1'b0;
    end

    // compare each delivered segment with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (segment_queue.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                want = segment_queue.pop_front();
                if (out_item.drawn !== want.drawn)
                    report_mismatch("drawn", out_item.drawn, want.drawn);
                if (out_item.is_point !== want.is_point)
                    report_mismatch("is_point", out_item.is_point, want.is_point);
                if (out_item.start_x !== want.start_x)
                    report_mismatch("start_x", out_item.start_x, want.start_x);
                if (out_item.start_y !== want.start_y)
                    report_mismatch("start_y", out_item.start_y, want.start_y);
                if (out_item.end_x !== want.end_x)
                    report_mismatch("end_x", out_item.end_x, want.end_x);
                if (out_item.end_y !== want.end_y)
                    report_mismatch("end_y", out_item.end_y, want.end_y);
                if (out_item.red !== want.red)
                    report_mismatch("red", out_item.red, want.red);
                if (out_item.green !== want.green)
                    report_mismatch("green", out_item.green, want.green);
                if (out_item.blue !== want.blue)
                    report_mismatch("blue", out_item.blue, want.blue);
                if (out_item.halted !== want.halted)
                    report_mismatch("halted", out_item.halted, want.halted);
                if (out_item.fault !== want.fault)
                    report_mismatch("fault", out_item.fault, want.fault);
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        int drain;
        idle_cycles = 0;
        drain = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_MAX)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (stimulus_done && segment_queue.size() == 0)
            begin
                drain++;
                if (drain >= 50)
                    break;
            end
        end
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/vdlp_pkg.sv
design/vdlp_mul.sv
design/vector_display_list_processor_unit.sv
test/vector_display_list_processor_unit_test.sv
